// ----- rtl/lpfd_pkg.sv -----
// ----------------------------------------------------------------------------
// lpfd_pkg
// Shared types and constants of the length-prefixed frame decoder: input
// opcodes, result kinds, status codes, register indexes and the queue entry.
// ----------------------------------------------------------------------------
package lpfd_pkg;

    // Header geometry: magic, version, type, flags, length, request id.
    localparam int HEADER_BYTES = 24;
    localparam int HCNT_W       = $clog2(HEADER_BYTES);
    // Bytes 0 to 22 are kept; byte 23 is taken straight from the input.
    localparam int HDR_KEEP_W   = (HEADER_BYTES - 1) * 8;

    // Queue between front and back.
    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_MAGIC  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VERSION      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_FRAME    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CTRL_LOW     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CTRL_HIGH    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_WORKER_LOW   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_WORKER_HIGH  = 3'd6;

    // Register reset values.
    localparam logic [31:0] RST_MAGIC       = 32'd0;
    localparam logic [15:0] RST_VERSION     = 16'd1;
    localparam logic [31:0] RST_MAX_FRAME   = 32'd65536;
    localparam logic [15:0] RST_CTRL_LOW    = 16'd1;
    localparam logic [15:0] RST_CTRL_HIGH   = 16'd15;
    localparam logic [15:0] RST_WORKER_LOW  = 16'd16;
    localparam logic [15:0] RST_WORKER_HIGH = 16'd20;

    // Input word opcodes.
    typedef enum logic [1:0] {
        OP_DATA  = 2'd0,
        OP_EOS   = 2'd1,
        OP_CLEAR = 2'd2
    } t_opcode;

    // Result word kinds.
    typedef enum logic [1:0] {
        KIND_PAYLOAD = 2'd0,
        KIND_EMPTY   = 2'd1,
        KIND_STATUS  = 2'd2
    } t_kind;

    // Status codes.
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_PROTO     = 2'd1,
        ST_VERSION   = 2'd2,
        ST_TOO_LARGE = 2'd3
    } t_status;

    // Decoder phase.
    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_PAYLOAD = 2'd1,
        PH_FAILED  = 2'd2
    } t_phase;

    // One result word as it travels through the queue.
    typedef struct packed {
        t_kind       kind;
        logic [7:0]  payload_byte;
        logic [15:0] message_type;
        logic [63:0] req_id;
        logic        last_of_frame;
        t_status     status;
    } t_result;

    // Queue status seen by the front and back.
    typedef struct packed {
        logic full;
        logic empty;
    } t_fifo_stat;

endpackage

// ----- rtl/lpfd_front.sv -----
// ----------------------------------------------------------------------------
// lpfd_front
// Accepts input words, collects and checks the frame header, tracks the
// payload count and the sticky failure, and pushes one result word per
// input word that produces one. Also holds the configuration registers.
// ----------------------------------------------------------------------------
module lpfd_front
    import lpfd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Input words
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [1:0]            i_opcode,
    input  logic [7:0]            i_data_byte,
    // Configuration writes
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // Queue side
    input  t_fifo_stat            i_fifo_stat,
    output logic                  o_push,
    output t_result               o_entry
);

    // Configuration registers; the length limit is kept already reduced
    // by the header size.
    logic [31:0] r_magic;
    logic [15:0] r_version;
    logic [31:0] r_len_lim;
    logic [15:0] r_ctrl_low;
    logic [15:0] r_ctrl_high;
    logic [15:0] r_worker_low;
    logic [15:0] r_worker_high;

    // Decoder state.
    t_phase                r_phase;
    t_phase                n_phase;
    logic [HCNT_W-1:0]     r_hcnt;
    logic [HCNT_W-1:0]     n_hcnt;
    logic [HDR_KEEP_W-1:0] r_hdr;
    logic [HDR_KEEP_W-1:0] n_hdr;
    logic [31:0]           r_remain;
    logic [31:0]           n_remain;
    logic [15:0]           r_type;
    logic [15:0]           n_type;
    logic [63:0]           r_id;
    logic [63:0]           n_id;
    t_status               r_fcode;
    t_status               n_fcode;

    logic        accept;
    logic        hdr_done;
    logic        pay_last;
    t_status     hdr_err;
    logic [15:0] hdr_type;
    logic [31:0] hdr_len;
    logic [63:0] hdr_id;
    logic        type_ok;

    assign o_ready = !i_fifo_stat.full;
    assign accept  = i_valid && o_ready;

    // Header fields, big endian, byte 0 at the top of the kept bytes.
    assign hdr_type = r_hdr[HDR_KEEP_W-49 -: 16];
    assign hdr_len  = r_hdr[HDR_KEEP_W-97 -: 32];
    assign hdr_id   = {r_hdr[55:0], i_data_byte};
    assign hdr_done = (r_hcnt == HCNT_W'(HEADER_BYTES - 1));
    assign pay_last = (r_remain <= 32'd1);

    assign type_ok = ((hdr_type >= r_ctrl_low) && (hdr_type <= r_ctrl_high)) ||
                     ((hdr_type >= r_worker_low) && (hdr_type <= r_worker_high));

    // Header checks in priority order; only stored bytes are involved.
    always_comb begin
        if (r_hdr[HDR_KEEP_W-1 -: 32] != r_magic) begin
            hdr_err = ST_PROTO;
        end else if (r_hdr[HDR_KEEP_W-33 -: 16] != r_version) begin
            hdr_err = ST_VERSION;
        end else if (!type_ok) begin
            hdr_err = ST_PROTO;
        end else if (r_hdr[HDR_KEEP_W-65 -: 32] != 32'd0) begin
            hdr_err = ST_PROTO;
        end else if (hdr_len > r_len_lim) begin
            hdr_err = ST_TOO_LARGE;
        end else begin
            hdr_err = ST_OK;
        end
    end

    // Configuration register writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_magic       <= RST_MAGIC;
            r_version     <= RST_VERSION;
            r_len_lim     <= RST_MAX_FRAME - 32'(HEADER_BYTES);
            r_ctrl_low    <= RST_CTRL_LOW;
            r_ctrl_high   <= RST_CTRL_HIGH;
            r_worker_low  <= RST_WORKER_LOW;
            r_worker_high <= RST_WORKER_HIGH;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_FRAME_MAGIC: r_magic <= i_cfg_data;
                CFG_VERSION:     r_version <= i_cfg_data[15:0];
                CFG_MAX_FRAME: begin
                    // A limit below the header size acts as the header size.
                    if (i_cfg_data < 32'(HEADER_BYTES)) begin
                        r_len_lim <= 32'd0;
                    end else begin
                        r_len_lim <= i_cfg_data - 32'(HEADER_BYTES);
                    end
                end
                CFG_CTRL_LOW:    r_ctrl_low <= i_cfg_data[15:0];
                CFG_CTRL_HIGH:   r_ctrl_high <= i_cfg_data[15:0];
                CFG_WORKER_LOW:  r_worker_low <= i_cfg_data[15:0];
                CFG_WORKER_HIGH: r_worker_high <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // Next phase.
    always_comb begin
        n_phase = r_phase;
        if (accept) begin
            case (t_opcode'(i_opcode))
                OP_CLEAR: n_phase = PH_HEADER;
                OP_DATA: begin
                    case (r_phase)
                        PH_HEADER: begin
                            if (hdr_done) begin
                                if (hdr_err != ST_OK) begin
                                    n_phase = PH_FAILED;
                                end else if (hdr_len != 32'd0) begin
                                    n_phase = PH_PAYLOAD;
                                end
                            end
                        end
                        PH_PAYLOAD: begin
                            if (pay_last) begin
                                n_phase = PH_HEADER;
                            end
                        end
                        default: ;
                    endcase
                end
                default: ;
            endcase
        end
    end

    // Datapath updates and the result word.
    always_comb begin
        n_hcnt   = r_hcnt;
        n_hdr    = r_hdr;
        n_remain = r_remain;
        n_type   = r_type;
        n_id     = r_id;
        n_fcode  = r_fcode;
        o_push   = 1'b0;
        o_entry  = '0;
        if (accept) begin
            case (t_opcode'(i_opcode))
                OP_CLEAR: begin
                    n_hcnt   = '0;
                    n_remain = '0;
                    n_fcode  = ST_PROTO;
                end
                OP_EOS: begin
                    o_push       = 1'b1;
                    o_entry.kind = KIND_STATUS;
                    if (r_phase == PH_FAILED) begin
                        o_entry.status = r_fcode;
                    end else if ((r_hcnt != '0) || (r_phase == PH_PAYLOAD)) begin
                        o_entry.status = ST_PROTO;
                    end else begin
                        o_entry.status = ST_OK;
                    end
                end
                OP_DATA: begin
                    case (r_phase)
                        PH_FAILED: begin
                            o_push         = 1'b1;
                            o_entry.kind   = KIND_STATUS;
                            o_entry.status = r_fcode;
                        end
                        PH_PAYLOAD: begin
                            o_push                = 1'b1;
                            o_entry.kind          = KIND_PAYLOAD;
                            o_entry.payload_byte  = i_data_byte;
                            o_entry.message_type  = r_type;
                            o_entry.req_id        = r_id;
                            o_entry.last_of_frame = pay_last;
                            n_remain = pay_last ? 32'd0 : r_remain - 32'd1;
                        end
                        default: begin
                            if (!hdr_done) begin
                                n_hdr  = {r_hdr[HDR_KEEP_W-9:0], i_data_byte};
                                n_hcnt = r_hcnt + HCNT_W'(1);
                            end else begin
                                n_hcnt = '0;
                                if (hdr_err != ST_OK) begin
                                    n_fcode        = hdr_err;
                                    o_push         = 1'b1;
                                    o_entry.kind   = KIND_STATUS;
                                    o_entry.status = hdr_err;
                                end else begin
                                    n_type   = hdr_type;
                                    n_id     = hdr_id;
                                    n_remain = hdr_len;
                                    // An empty payload closes the frame at once.
                                    if (hdr_len == 32'd0) begin
                                        o_push                = 1'b1;
                                        o_entry.kind          = KIND_EMPTY;
                                        o_entry.message_type  = hdr_type;
                                        o_entry.req_id        = hdr_id;
                                        o_entry.last_of_frame = 1'b1;
                                    end
                                end
                            end
                        end
                    endcase
                end
                default: ;
            endcase
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HEADER;
            r_hcnt   <= '0;
            r_remain <= '0;
            r_fcode  <= ST_PROTO;
        end else begin
            r_phase  <= n_phase;
            r_hcnt   <= n_hcnt;
            r_remain <= n_remain;
            r_fcode  <= n_fcode;
        end
    end

    // Header bytes and frame tags.
    always_ff @(posedge i_clk) begin
        r_hdr  <= n_hdr;
        r_type <= n_type;
        r_id   <= n_id;
    end

    // A frame in its payload always has bytes left to come.
    a_payload_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_PAYLOAD) |-> (r_remain != 32'd0))
        else $error("payload phase with zero bytes remaining");

    // Header collection only runs in the header phase.
    a_hcnt_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase != PH_HEADER) |-> (r_hcnt == '0))
        else $error("header count nonzero outside header phase");

    // The header count never passes the last header byte.
    a_hcnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hcnt <= HCNT_W'(HEADER_BYTES - 1))
        else $error("header count out of range");

    // A failed decoder carries an error code, never ok.
    a_fail_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_FAILED) |-> (r_fcode != ST_OK))
        else $error("failed decoder without an error code");

endmodule

// ----- rtl/lpfd_fifo.sv -----
// ----------------------------------------------------------------------------
// lpfd_fifo
// Short result queue between the front and the back, so that each side
// can stall on its own.
// ----------------------------------------------------------------------------
module lpfd_fifo
    import lpfd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  t_result    i_entry,
    input  logic       i_pop,
    output t_result    o_entry,
    output t_fifo_stat o_stat
);

    t_result            r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wptr;
    logic [FIFO_AW-1:0] r_rptr;
    logic [FIFO_CW-1:0] r_count;
    logic               do_push;
    logic               do_pop;

    assign o_stat.full  = (r_count == FIFO_CW'(FIFO_DEPTH));
    assign o_stat.empty = (r_count == '0);
    assign do_push      = i_push && !o_stat.full;
    assign do_pop       = i_pop && !o_stat.empty;
    assign o_entry      = r_mem[r_rptr];

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_entry;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= (r_wptr == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : r_wptr + FIFO_AW'(1);
            end
            if (do_pop) begin
                r_rptr <= (r_rptr == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : r_rptr + FIFO_AW'(1);
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + FIFO_CW'(1);
                2'b01:   r_count <= r_count - FIFO_CW'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ----- rtl/lpfd_back.sv -----
// ----------------------------------------------------------------------------
// lpfd_back
// Pops result words from the queue into the output register and presents
// them on the master side.
// ----------------------------------------------------------------------------
module lpfd_back
    import lpfd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_fifo_stat  i_fifo_stat,
    input  t_result     i_entry,
    output logic        o_pop,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [95:0] o_tdata,
    output logic        o_tlast,
    output logic [1:0]  o_tuser
);

    logic    r_valid;
    t_result r_word;

    // Refill the output register whenever it is empty or being taken.
    assign o_pop = !i_fifo_stat.empty && (!r_valid || i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_word <= i_entry;
        end
    end

    // Pack the word: payload byte, type, request id, status from bit 0 up.
    assign o_valid = r_valid;
    assign o_tdata = {6'd0, r_word.status, r_word.req_id,
                      r_word.message_type, r_word.payload_byte};
    assign o_tlast = r_word.last_of_frame;
    assign o_tuser = r_word.kind;

endmodule

// ----- rtl/length_prefixed_frame_decoder.sv -----
// ----------------------------------------------------------------------------
// length_prefixed_frame_decoder
// Decodes a byte stream of length-prefixed frames into tagged payload words.
// ----------------------------------------------------------------------------
// Usage:
//   The slave side takes one word per cycle: tuser carries the opcode (data
//   byte, end-of-stream check, clear) and tdata the stream byte. The decoder
//   collects the 24-byte header, checks it against the configuration
//   registers, and then passes payload bytes out tagged with type and request
//   id, with tlast on the last byte of a frame. An empty frame gives one word
//   of its own, errors and end-of-stream checks give status words. Throughput
//   is one word per cycle while tready is high, also across header ends; a
//   result word enters the queue as its input word is taken, then the output
//   register, which drives the master side. Words that make no result
//   (header bytes, clear) push nothing. A two-entry queue and the output
//   register sit between the decoder and the master side; when the receiver
//   stalls, the queue fills and tready on the slave side falls until words
//   drain again. Reset (synchronous, active low) restores the configuration
//   and control registers to their defaults and empties the queue. The user
//   must make config writes only while idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module length_prefixed_frame_decoder
    import lpfd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Input stream
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [7:0]            s_axis_tdata,   // [7:0] data_byte
    input  logic [1:0]            s_axis_tuser,   // [1:0] opcode
    // Result stream
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // [7:0] payload_byte, [23:8] message_type, [87:24] req_id,
    // [89:88] status, [95:90] zero
    output logic [95:0]           m_axis_tdata,
    output logic                  m_axis_tlast,   // last_of_frame
    output logic [1:0]            m_axis_tuser,   // [1:0] kind
    // Configuration writes
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_fifo_stat fifo_stat;
    logic       push;
    logic       pop;
    t_result    push_entry;
    t_result    pop_entry;

    lpfd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_opcode    (s_axis_tuser),
        .i_data_byte (s_axis_tdata),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_fifo_stat (fifo_stat),
        .o_push      (push),
        .o_entry     (push_entry)
    );

    lpfd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .i_pop   (pop),
        .o_entry (pop_entry),
        .o_stat  (fifo_stat)
    );

    lpfd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fifo_stat (fifo_stat),
        .i_entry     (pop_entry),
        .o_pop       (pop),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_tdata     (m_axis_tdata),
        .o_tlast     (m_axis_tlast),
        .o_tuser     (m_axis_tuser)
    );

endmodule

// ----- tb/lpfd_decode_checker.sv -----
// ----------------------------------------------------------------------------
// lpfd_decode_checker
// Watches both streams and the configuration port of the frame decoder. It
// keeps its own copy of the registers and of the decoder state, works out
// the result word that each accepted input word must cause, and compares the
// result words in order, field by field.
// ----------------------------------------------------------------------------
module lpfd_decode_checker
    import lpfd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    input  logic                  s_axis_tready,
    input  logic [7:0]            s_axis_tdata,   // [7:0] data_byte
    input  logic [1:0]            s_axis_tuser,   // [1:0] opcode
    input  logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // [7:0] payload_byte, [23:8] message_type, [87:24] req_id,
    // [89:88] status, [95:90] zero
    input  logic [95:0]           m_axis_tdata,
    input  logic                  m_axis_tlast,   // last_of_frame
    input  logic [1:0]            m_axis_tuser,   // [1:0] kind
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_mismatches,
    output int                    o_pending,
    output int                    o_payload_words,
    output int                    o_empty_frames,
    output int                    o_status_words
);
    timeunit 1ns;
    timeprecision 1ps;

    // Copy of the configuration registers.
    logic [31:0] reg_magic;
    logic [15:0] reg_version;
    logic [31:0] reg_max_size;
    logic [15:0] reg_ctrl_lo;
    logic [15:0] reg_ctrl_hi;
    logic [15:0] reg_wrk_lo;
    logic [15:0] reg_wrk_hi;

    // Copy of the decoder state.
    logic [7:0]  hdr_bytes [HEADER_BYTES];
    int unsigned hdr_count;
    bit          in_payload;
    logic [31:0] bytes_left;
    logic [15:0] cur_type;
    logic [63:0] cur_id;
    bit          is_failed;
    t_status     fail_code;

    // Result words still to come, oldest first.
    t_result expected_words [$];
    int      mismatches;
    int      payload_seen;
    int      empty_seen;
    int      status_seen;

    // Big-endian fields of the collected header.
    function automatic logic [15:0] hdr16(int at);
        return {hdr_bytes[at], hdr_bytes[at + 1]};
    endfunction

    function automatic logic [31:0] hdr32(int at);
        return {hdr16(at), hdr16(at + 2)};
    endfunction

    function automatic void drop_frame();
        in_payload = 1'b0;
        bytes_left = '0;
        cur_type   = '0;
        cur_id     = '0;
    endfunction

    function automatic void clear_decoder();
        foreach (hdr_bytes[i]) hdr_bytes[i] = 8'h00;
        hdr_count = 0;
        drop_frame();
        is_failed = 1'b0;
        fail_code = ST_PROTO;
    endfunction

    // Checks run in a fixed order and the first failing one gives the code.
    function automatic t_status header_verdict();
        logic [15:0] typ;
        logic [31:0] room;
        bit          ctrl_ok;
        bit          wrk_ok;
        typ     = hdr16(6);
        // A limit below the header size behaves as exactly the header size.
        room    = (reg_max_size < 32'(HEADER_BYTES)) ? 32'd0
                                                     : reg_max_size - 32'(HEADER_BYTES);
        ctrl_ok = (typ >= reg_ctrl_lo) && (typ <= reg_ctrl_hi);
        wrk_ok  = (typ >= reg_wrk_lo) && (typ <= reg_wrk_hi);
        if (hdr32(0) != reg_magic)
            return ST_PROTO;
        if (hdr16(4) != reg_version)
            return ST_VERSION;
        if (!(ctrl_ok || wrk_ok))
            return ST_PROTO;
        if (hdr32(8) != 32'd0)
            return ST_PROTO;
        if (hdr32(12) > room)
            return ST_TOO_LARGE;
        return ST_OK;
    endfunction

    function automatic t_result make_word(t_kind k, logic [7:0] b, logic [15:0] typ,
                                          logic [63:0] id, logic last, t_status st);
        t_result w;
        w.kind          = k;
        w.payload_byte  = b;
        w.message_type  = typ;
        w.req_id        = id;
        w.last_of_frame = last;
        w.status        = st;
        return w;
    endfunction

    // Advances the state copy by one input word; returns 1 when a result
    // word is due and places it in w.
    function automatic bit decode_word(logic [1:0] op, logic [7:0] b, output t_result w);
        t_status verdict;
        bit      last;
        w = '0;
        case (op)
            OP_CLEAR: begin
                clear_decoder();
                return 1'b0;
            end
            OP_EOS: begin
                if (is_failed)
                    verdict = fail_code;
                else if (hdr_count != 0 || in_payload)
                    verdict = ST_PROTO;
                else
                    verdict = ST_OK;
                w = make_word(KIND_STATUS, 8'h00, 16'h0000, 64'h0, 1'b0, verdict);
                return 1'b1;
            end
            OP_DATA: ;
            default: return 1'b0;
        endcase

        // A failed decoder answers every data byte with its sticky code.
        if (is_failed) begin
            w = make_word(KIND_STATUS, 8'h00, 16'h0000, 64'h0, 1'b0, fail_code);
            return 1'b1;
        end

        if (in_payload) begin
            last = (bytes_left <= 32'd1);
            w = make_word(KIND_PAYLOAD, b, cur_type, cur_id, last, ST_OK);
            if (last)
                drop_frame();
            else
                bytes_left = bytes_left - 32'd1;
            return 1'b1;
        end

        // Header collection; only the byte that completes it can give a word.
        hdr_bytes[hdr_count] = b;
        hdr_count++;
        if (hdr_count < HEADER_BYTES)
            return 1'b0;
        hdr_count = 0;
        verdict = header_verdict();
        if (verdict != ST_OK) begin
            foreach (hdr_bytes[i]) hdr_bytes[i] = 8'h00;
            drop_frame();
            is_failed = 1'b1;
            fail_code = verdict;
            w = make_word(KIND_STATUS, 8'h00, 16'h0000, 64'h0, 1'b0, verdict);
            return 1'b1;
        end
        cur_type   = hdr16(6);
        cur_id     = {hdr32(16), hdr32(20)};
        bytes_left = hdr32(12);
        if (bytes_left == 32'd0) begin
            w = make_word(KIND_EMPTY, 8'h00, cur_type, cur_id, 1'b1, ST_OK);
            drop_frame();
            return 1'b1;
        end
        in_payload = 1'b1;
        return 1'b0;
    endfunction

    function automatic void compare_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
        end
    endfunction

    // Registers, prediction and comparison, all sampled at the rising edge.
    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            reg_magic    = RST_MAGIC;
            reg_version  = RST_VERSION;
            reg_max_size = RST_MAX_FRAME;
            reg_ctrl_lo  = RST_CTRL_LOW;
            reg_ctrl_hi  = RST_CTRL_HIGH;
            reg_wrk_lo   = RST_WORKER_LOW;
            reg_wrk_hi   = RST_WORKER_HIGH;
            clear_decoder();
            expected_words.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_FRAME_MAGIC: reg_magic    = i_cfg_data;
                    CFG_VERSION:     reg_version  = i_cfg_data[15:0];
                    CFG_MAX_FRAME:   reg_max_size = i_cfg_data;
                    CFG_CTRL_LOW:    reg_ctrl_lo  = i_cfg_data[15:0];
                    CFG_CTRL_HIGH:   reg_ctrl_hi  = i_cfg_data[15:0];
                    CFG_WORKER_LOW:  reg_wrk_lo   = i_cfg_data[15:0];
                    CFG_WORKER_HIGH: reg_wrk_hi   = i_cfg_data[15:0];
                    default: ;
                endcase
            end

            if (s_axis_tvalid && s_axis_tready) begin
                if (decode_word(s_axis_tuser, s_axis_tdata, want))
                    expected_words.insert(expected_words.size(), want);
            end

            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_words.size() == 0) begin
                    mismatches++;
                    $display("%0t: result word with nothing expected, tuser %0h tdata %0h",
                             $time, m_axis_tuser, m_axis_tdata);
                end else begin
                    want = expected_words.pop_front();
                    compare_field("kind", want.kind, m_axis_tuser);
                    compare_field("payload_byte", want.payload_byte, m_axis_tdata[7:0]);
                    compare_field("message_type", want.message_type, m_axis_tdata[23:8]);
                    compare_field("req_id", want.req_id, m_axis_tdata[87:24]);
                    compare_field("last_of_frame", want.last_of_frame, m_axis_tlast);
                    compare_field("status", want.status, m_axis_tdata[89:88]);
                end
                if (m_axis_tuser == KIND_PAYLOAD)
                    payload_seen++;
                else if (m_axis_tuser == KIND_EMPTY)
                    empty_seen++;
                else
                    status_seen++;
            end
        end
        o_pending       <= expected_words.size();
        o_mismatches    <= mismatches;
        o_payload_words <= payload_seen;
        o_empty_frames  <= empty_seen;
        o_status_words  <= status_seen;
    end

endmodule

// ----- tb/length_prefixed_frame_decoder_tb.sv -----
// ----------------------------------------------------------------------------
// length_prefixed_frame_decoder_tb
// Drives the frame decoder with well-formed frames of random content, broken
// headers, truncated frames and noise over several register settings, with
// random gaps on the input and random stalls on the output. The checker
// beside the decoder predicts and compares every result word.
// ----------------------------------------------------------------------------
module length_prefixed_frame_decoder_tb
    import lpfd_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int         IDLE_LIMIT    = 2000;
    localparam int         SETTLE_CYCLES = 8;
    localparam logic [1:0] OP_UNUSED     = 2'd3;

    typedef struct {
        logic [31:0] magic;
        logic [15:0] version;
        logic [31:0] max_size;
        logic [15:0] ctrl_lo;
        logic [15:0] ctrl_hi;
        logic [15:0] wrk_lo;
        logic [15:0] wrk_hi;
    } t_regs;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [7:0]            s_axis_tdata;
    logic [1:0]            s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [95:0]           m_axis_tdata;
    logic                  m_axis_tlast;
    logic [1:0]            m_axis_tuser;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    int    mismatches;
    int    pending;
    int    payload_words;
    int    empty_frames;
    int    status_words;
    int    idle_cycles;
    int    words_sent;
    bit    calm;
    t_regs regs;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    length_prefixed_frame_decoder DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    lpfd_decode_checker u_decode_check (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .s_axis_tvalid   (s_axis_tvalid),
        .s_axis_tready   (s_axis_tready),
        .s_axis_tdata    (s_axis_tdata),
        .s_axis_tuser    (s_axis_tuser),
        .m_axis_tvalid   (m_axis_tvalid),
        .m_axis_tready   (m_axis_tready),
        .m_axis_tdata    (m_axis_tdata),
        .m_axis_tlast    (m_axis_tlast),
        .m_axis_tuser    (m_axis_tuser),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_mismatches    (mismatches),
        .o_pending       (pending),
        .o_payload_words (payload_words),
        .o_empty_frames  (empty_frames),
        .o_status_words  (status_words)
    );

    // Gap length for either side: mostly none, some short, a few long.
    function automatic int pick_gap();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 19);
        if (r < 12)
            return 0;
        if (r < 19)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Payload bytes that the current limit allows after the header.
    function automatic logic [31:0] frame_room();
        if (regs.max_size < 32'(HEADER_BYTES))
            return 32'd0;
        return regs.max_size - 32'(HEADER_BYTES);
    endfunction

    // A type from a non-empty range, or any type when both ranges are empty.
    function automatic logic [15:0] pick_type();
        bit ctrl_ok;
        bit wrk_ok;
        ctrl_ok = regs.ctrl_lo <= regs.ctrl_hi;
        wrk_ok  = regs.wrk_lo <= regs.wrk_hi;
        if (ctrl_ok && (!wrk_ok || $urandom_range(0, 1) == 0))
            return 16'($urandom_range(regs.ctrl_lo, regs.ctrl_hi));
        if (wrk_ok)
            return 16'($urandom_range(regs.wrk_lo, regs.wrk_hi));
        return 16'($urandom);
    endfunction

    // Mostly short payloads, some empty, now and then the full allowance.
    function automatic logic [31:0] pick_len();
        logic [31:0] len;
        int          r;
        r = $urandom_range(0, 19);
        if (r < 3)
            len = 32'd0;
        else if (r < 16)
            len = $urandom_range(1, 12);
        else if (r < 19)
            len = $urandom_range(13, 40);
        else
            len = frame_room();
        return (len > frame_room()) ? frame_room() : len;
    endfunction

    // Offers one word after a random gap and returns at the edge that takes it.
    task automatic send_word(logic [1:0] op, logic [7:0] b);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tuser  <= op;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        if (op != OP_UNUSED)
            words_sent++;
    endtask

    // Sends the first upto bytes of a big-endian header.
    task automatic send_header(logic [31:0] magic, logic [15:0] ver, logic [15:0] typ,
                               logic [31:0] flags, logic [31:0] len, logic [63:0] id,
                               int upto = HEADER_BYTES);
        logic [191:0] hdr;
        hdr = {magic, ver, typ, flags, len, id};
        for (int i = 0; i < upto; i++)
            send_word(OP_DATA, hdr[191 - 8 * i -: 8]);
    endtask

    // A well-formed frame; one too long to stream whole is cut short and cleared.
    task automatic send_good_frame();
        logic [31:0] len;
        len = pick_len();
        send_header(regs.magic, regs.version, pick_type(), 32'd0, len, {$urandom, $urandom});
        if (len <= 32'd64) begin
            repeat (len) send_word(OP_DATA, 8'($urandom));
        end else begin
            repeat ($urandom_range(0, 8)) send_word(OP_DATA, 8'($urandom));
            send_word(OP_EOS, 8'h00);
            send_word(OP_CLEAR, 8'h00);
        end
    endtask

    // One or two header fields spoiled, then bytes into the failed decoder.
    task automatic send_bad_frame();
        logic [31:0] magic;
        logic [15:0] ver;
        logic [15:0] typ;
        logic [31:0] flags;
        logic [31:0] len;
        magic = regs.magic;
        ver   = regs.version;
        typ   = pick_type();
        flags = 32'd0;
        len   = pick_len();
        if (len > 32'd16)
            len = 32'd16;
        repeat ($urandom_range(1, 2)) begin
            case ($urandom_range(0, 4))
                0: magic = regs.magic ^ (32'd1 << $urandom_range(0, 31));
                1: ver   = regs.version ^ (16'd1 << $urandom_range(0, 15));
                2: typ   = 16'($urandom);
                3: flags = $urandom | (32'd1 << $urandom_range(0, 31));
                default: len = frame_room() + 32'($urandom_range(1, 1000));
            endcase
        end
        send_header(magic, ver, typ, flags, len, {$urandom, $urandom});
        repeat ($urandom_range(1, 5)) send_word(OP_DATA, 8'($urandom));
        send_word(OP_EOS, 8'h00);
        send_word(OP_CLEAR, 8'h00);
    endtask

    // Stream ends inside a header or inside a payload.
    task automatic send_truncated();
        logic [31:0] room;
        logic [31:0] len;
        room = frame_room();
        if (room >= 32'd2 && $urandom_range(0, 1) == 1) begin
            len = $urandom_range(2, (room > 32'd20) ? 32'd20 : room);
            send_header(regs.magic, regs.version, pick_type(), 32'd0, len,
                        {$urandom, $urandom});
            repeat ($urandom_range(1, len - 1)) send_word(OP_DATA, 8'($urandom));
        end else begin
            send_header(regs.magic, regs.version, pick_type(), 32'd0, pick_len(),
                        {$urandom, $urandom}, $urandom_range(1, HEADER_BYTES - 1));
        end
        send_word(OP_EOS, 8'h00);
        send_word(OP_CLEAR, 8'h00);
    endtask

    // Random words of any opcode, followed by a clear to get back in step.
    task automatic send_noise();
        repeat ($urandom_range(1, 8)) send_word(2'($urandom), 8'($urandom));
        send_word(OP_CLEAR, 8'h00);
    endtask

    // Holds the input until every expected word has come out.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
    endtask

    task automatic write_regs(t_regs r);
        regs = r;
        cfg_write(CFG_FRAME_MAGIC, r.magic);
        cfg_write(CFG_VERSION, 32'(r.version));
        cfg_write(CFG_MAX_FRAME, r.max_size);
        cfg_write(CFG_CTRL_LOW, 32'(r.ctrl_lo));
        cfg_write(CFG_CTRL_HIGH, 32'(r.ctrl_hi));
        cfg_write(CFG_WORKER_LOW, 32'(r.wrk_lo));
        cfg_write(CFG_WORKER_HIGH, 32'(r.wrk_hi));
        i_cfg_we <= 1'b0;
    endtask

    // Register settings of the later phases: extremes, tight limits, random.
    function automatic t_regs phase_regs(int phase);
        t_regs r;
        case (phase)
            2: begin
                r = '{32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 16'h0000, 16'h0000,
                      16'hFFFF, 16'hFFFF};
            end
            3: begin
                r = '{$urandom, 16'h0000, 32'd24, 16'd10, 16'd3, 16'h0000, 16'hFFFF};
            end
            4: begin
                r.magic    = $urandom;
                r.version  = 16'($urandom);
                r.max_size = 32'd24 + $urandom_range(0, 60);
                r.ctrl_lo  = 16'($urandom);
                r.ctrl_hi  = r.ctrl_lo + 16'($urandom_range(0, 50));
                r.wrk_lo   = 16'($urandom);
                r.wrk_hi   = r.wrk_lo + 16'($urandom_range(0, 50));
            end
            default: begin
                r = '{32'h0000_0000, 16'($urandom), 32'($urandom_range(0, 23)),
                      16'd200, 16'd300, 16'd100, 16'd50};
            end
        endcase
        return r;
    endfunction

    // Mostly good frames, the rest broken ones and noise; one full drain midway.
    task automatic random_traffic(int count);
        int  start;
        int  r;
        bit  paused;
        start  = words_sent;
        paused = 1'b0;
        while (words_sent - start < count) begin
            r = $urandom_range(0, 99);
            if (r < 68)
                send_good_frame();
            else if (r < 78)
                send_bad_frame();
            else if (r < 86)
                send_truncated();
            else if (r < 93)
                send_noise();
            else begin
                case ($urandom_range(0, 2))
                    0: send_word(OP_EOS, 8'($urandom));
                    1: send_word(OP_UNUSED, 8'($urandom));
                    default: send_word(OP_CLEAR, 8'($urandom));
                endcase
            end
            if (!paused && words_sent - start > count / 2) begin
                paused = 1'b1;
                drain();
            end
        end
    endtask

    // Receiver: ready in random bursts with stalls of random length.
    initial begin
        int gap;
        m_axis_tready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            gap = pick_gap();
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
    end

    // Watchdog on cycles without any word moving on either side.
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || i_cfg_we) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("%0t: no word moved for %0d cycles", $time, IDLE_LIMIT);
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // Stimulus and verdict.
    initial begin
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= 8'h00;
        s_axis_tuser  <= OP_DATA;
        i_cfg_we      <= 1'b0;
        i_cfg_index   <= CFG_FRAME_MAGIC;
        i_cfg_data    <= '0;
        words_sent    = 0;
        calm          = 1'b1;
        regs = '{RST_MAGIC, RST_VERSION, RST_MAX_FRAME, RST_CTRL_LOW, RST_CTRL_HIGH,
                 RST_WORKER_LOW, RST_WORKER_HIGH};
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: idle end-of-stream, unused opcode, empty frame, clear.
        send_word(OP_EOS, 8'h00);
        send_word(OP_UNUSED, 8'hFF);
        send_header(RST_MAGIC, RST_VERSION, RST_CTRL_LOW, 32'd0, 32'd0,
                    64'hFFFF_FFFF_FFFF_FFFF);
        send_word(OP_CLEAR, 8'h00);
        calm = 1'b0;

        // Reset register values first, then the other settings.
        random_traffic(200);
        for (int phase = 2; phase <= 5; phase++) begin
            drain();
            write_regs(phase_regs(phase));
            calm = (phase == 2);
            random_traffic((phase == 3 || phase == 5) ? 100 : 200);
        end
        drain();

        $display("Sent %0d input words over five register settings, with drains between.",
                 words_sent);
        $display("Checked %0d payload bytes, %0d empty frames and %0d status words.",
                 payload_words, empty_frames, status_words);
        if (mismatches == 0 && pending == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ----- length_prefixed_frame_decoder.f -----
rtl/lpfd_pkg.sv
rtl/lpfd_front.sv
rtl/lpfd_fifo.sv
rtl/lpfd_back.sv
rtl/length_prefixed_frame_decoder.sv
tb/lpfd_decode_checker.sv
tb/length_prefixed_frame_decoder_tb.sv
